// ===== rtl/core/sandpile_drop_avalanche_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sandpile drop avalanche unit assertion macros
// concurrent checks, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef SANDPILE_DROP_AVALANCHE_UNIT_MACROS_SVH
`define SANDPILE_DROP_AVALANCHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define SDA_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`define SDA_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`else

`define SDA_ASSERT(name, expr, msg)

`define SDA_ASSERT_NEXT(name, cond, expr, msg)

`endif

`endif

// ===== rtl/core/sda_pkg.sv =====
// ----------------------------------------------------------------------------
// sda_pkg
// shared constants, types and helpers of the sandpile drop avalanche unit
// ----------------------------------------------------------------------------
package sda_pkg;

   localparam int GRID_SIDE_DEF = 64;
   localparam int COORD_IN_W    = 6;
   localparam int REQ_DATA_W    = 16;
   localparam int SIZE_W        = 24;
   localparam int GRAIN_W       = 4;

   localparam logic [GRAIN_W-1:0] TOPPLE_AT = GRAIN_W'(4);
   localparam logic [GRAIN_W-1:0] GRAIN_MAX = GRAIN_W'(15);
   localparam logic [SIZE_W-1:0]  SIZE_MAX  = {SIZE_W{1'b1}};

   localparam logic [1:0] NB_DOWN  = 2'd0;
   localparam logic [1:0] NB_UP    = 2'd1;
   localparam logic [1:0] NB_RIGHT = 2'd2;
   localparam logic [1:0] NB_LEFT  = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DROP_WR,
      ST_POP,
      ST_CELL_RD,
      ST_CELL,
      ST_NB,
      ST_NB_WR,
      ST_SELF,
      ST_DONE
   } state_type;

   function automatic logic [GRAIN_W-1:0] grain_inc(input logic [GRAIN_W-1:0] g);
      grain_inc = (g == GRAIN_MAX) ? GRAIN_MAX : g + GRAIN_W'(1);
   endfunction

   function automatic logic [SIZE_W-1:0] size_inc(input logic [SIZE_W-1:0] s);
      size_inc = (s == SIZE_MAX) ? SIZE_MAX : s + SIZE_W'(1);
   endfunction

endpackage

// ===== rtl/core/sandpile_drop_avalanche_unit.sv =====
// ----------------------------------------------------------------------------
// sandpile drop avalanche unit
// drops one grain per request word on a square grid and returns the number
// of topplings of the avalanche it sets off
//
// req channel: one word per drop, column in bits 5:0, row in bits 11:6.
// rsp channel: one word per drop, the 24-bit saturating toppling count.
// grain counts sit in a one-port-read, one-port-write grid memory; the work
// list of cells to topple sits in a second memory used as a fifo.
// a word whose column or row lies off the grid drops nothing and returns a
// count of zero. a drop that topples nothing writes its cell and goes
// straight to the result. each toppled cell takes a fifo read, a grid read,
// a center write and a read and a write for each neighbour on the grid,
// then a requeue check; the single grid memory port serializes these steps.
// after reset the unit sweeps the grid memory to zero, one entry a cycle
// (4096 entries at the default 64 x 64 grid), with req_tready low.
// a stalled rsp side holds the result register; the next drop is still
// accepted and runs, and waits at its end until the register frees up.
// ----------------------------------------------------------------------------
`include "sandpile_drop_avalanche_unit_macros.svh"

module sandpile_drop_avalanche_unit #(
   parameter int GRID_SIDE = sda_pkg::GRID_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sda_pkg::REQ_DATA_W-1:0] req_tdata,  // drop_x, drop_y, zero fill
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sda_pkg::SIZE_W-1:0]     rsp_tdata   // topple count
);

   localparam int COORD_W   = $clog2(GRID_SIDE);
   localparam int ADDR_W    = 2 * COORD_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int XW        = (COORD_W + 1 > sda_pkg::COORD_IN_W) ?
                              COORD_W + 1 : sda_pkg::COORD_IN_W;
   localparam logic [XW-1:0]      SIDE_X   = XW'(GRID_SIDE);
   localparam logic [COORD_W-1:0] LAST_POS = COORD_W'(GRID_SIDE - 1);
   localparam logic [ADDR_W:0]    Q_FULL   = (ADDR_W + 1)'(MEM_DEPTH);

   localparam int GW = sda_pkg::GRAIN_W;
   localparam int SW = sda_pkg::SIZE_W;

   // memories
   logic [GW-1:0]     grain_mem_ff [MEM_DEPTH];
   logic [ADDR_W-1:0] queue_mem_ff [MEM_DEPTH];
   logic [GW-1:0]     grain_rd_ff;
   logic [ADDR_W-1:0] queue_rd_ff;

   // control and payload registers
   sda_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [GW-1:0]     self_ff, self_in;
   logic [1:0]        nb_ff, nb_in;
   logic [SW-1:0]     size_ff, size_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [ADDR_W:0]   count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]     rsp_data_ff, rsp_data_in;

   // memory ports
   logic              g_re, g_we, q_re, q_we;
   logic [ADDR_W-1:0] g_raddr, g_waddr, q_waddr, q_wdata;
   logic [GW-1:0]     g_wdata, g_inc;

   // drop decode
   logic [XW-1:0]      x_ext, y_ext;
   logic               drop_ok;
   logic [ADDR_W-1:0]  drop_addr;

   // neighbour select
   logic [COORD_W-1:0] cur_row, cur_col;
   logic [ADDR_W-1:0]  nb_addr;
   logic               nb_ok;
   logic               q_room;

   assign x_ext     = XW'(req_tdata[sda_pkg::COORD_IN_W-1:0]);
   assign y_ext     = XW'(req_tdata[2*sda_pkg::COORD_IN_W-1:sda_pkg::COORD_IN_W]);
   assign drop_ok   = (x_ext < SIDE_X) && (y_ext < SIDE_X);
   assign drop_addr = {y_ext[COORD_W-1:0], x_ext[COORD_W-1:0]};

   assign cur_row = cur_ff[ADDR_W-1:COORD_W];
   assign cur_col = cur_ff[COORD_W-1:0];
   assign g_inc   = sda_pkg::grain_inc(grain_rd_ff);
   assign q_room  = (count_ff != Q_FULL);

   always_comb begin
      unique case (nb_ff)
         sda_pkg::NB_DOWN: begin
            nb_ok   = (cur_row != LAST_POS);
            nb_addr = {cur_row + COORD_W'(1), cur_col};
         end
         sda_pkg::NB_UP: begin
            nb_ok   = (cur_row != '0);
            nb_addr = {cur_row - COORD_W'(1), cur_col};
         end
         sda_pkg::NB_RIGHT: begin
            nb_ok   = (cur_col != LAST_POS);
            nb_addr = {cur_row, cur_col + COORD_W'(1)};
         end
         default: begin
            nb_ok   = (cur_col != '0);
            nb_addr = {cur_row, cur_col - COORD_W'(1)};
         end
      endcase
   end

   assign req_tready = (state_ff == sda_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      self_in      = self_ff;
      nb_in        = nb_ff;
      size_in      = size_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      g_re         = 1'b0;
      g_raddr      = nb_addr;
      g_we         = 1'b0;
      g_waddr      = nb_addr;
      g_wdata      = g_inc;
      q_re         = 1'b0;
      q_we         = 1'b0;
      q_waddr      = tail_ff;
      q_wdata      = nb_addr;

      unique case (state_ff)
         sda_pkg::ST_CLEAR: begin
            g_we       = 1'b1;
            g_waddr    = clr_cnt_ff;
            g_wdata    = '0;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (&clr_cnt_ff) begin
               state_in = sda_pkg::ST_IDLE;
            end
         end
         sda_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               start_in = drop_addr;
               size_in  = '0;
               if (drop_ok) begin
                  g_re     = 1'b1;
                  g_raddr  = drop_addr;
                  state_in = sda_pkg::ST_DROP_WR;
               end else begin
                  state_in = sda_pkg::ST_DONE;
               end
            end
         end
         sda_pkg::ST_DROP_WR: begin
            g_we    = 1'b1;
            g_waddr = start_ff;
            if (g_inc >= sda_pkg::TOPPLE_AT) begin
               q_we     = 1'b1;
               q_waddr  = '0;
               q_wdata  = start_ff;
               head_in  = '0;
               tail_in  = ADDR_W'(1);
               count_in = (ADDR_W + 1)'(1);
               state_in = sda_pkg::ST_POP;
            end else begin
               state_in = sda_pkg::ST_DONE;
            end
         end
         sda_pkg::ST_POP: begin
            if (count_ff == '0) begin
               state_in = sda_pkg::ST_DONE;
            end else begin
               q_re     = 1'b1;
               head_in  = head_ff + ADDR_W'(1);
               count_in = count_ff - (ADDR_W + 1)'(1);
               state_in = sda_pkg::ST_CELL_RD;
            end
         end
         sda_pkg::ST_CELL_RD: begin
            cur_in   = queue_rd_ff;
            g_re     = 1'b1;
            g_raddr  = queue_rd_ff;
            state_in = sda_pkg::ST_CELL;
         end
         sda_pkg::ST_CELL: begin
            if (grain_rd_ff < sda_pkg::TOPPLE_AT) begin
               state_in = sda_pkg::ST_POP;
            end else begin
               g_we     = 1'b1;
               g_waddr  = cur_ff;
               g_wdata  = grain_rd_ff - sda_pkg::TOPPLE_AT;
               self_in  = grain_rd_ff - sda_pkg::TOPPLE_AT;
               size_in  = sda_pkg::size_inc(size_ff);
               nb_in    = sda_pkg::NB_DOWN;
               state_in = sda_pkg::ST_NB;
            end
         end
         sda_pkg::ST_NB: begin
            if (nb_ok) begin
               g_re     = 1'b1;
               state_in = sda_pkg::ST_NB_WR;
            end else if (nb_ff == sda_pkg::NB_LEFT) begin
               state_in = sda_pkg::ST_SELF;
            end else begin
               nb_in = nb_ff + 2'd1;
            end
         end
         sda_pkg::ST_NB_WR: begin
            g_we = 1'b1;
            if (g_inc == sda_pkg::TOPPLE_AT && q_room) begin
               q_we     = 1'b1;
               tail_in  = tail_ff + ADDR_W'(1);
               count_in = count_ff + (ADDR_W + 1)'(1);
            end
            if (nb_ff == sda_pkg::NB_LEFT) begin
               state_in = sda_pkg::ST_SELF;
            end else begin
               nb_in    = nb_ff + 2'd1;
               state_in = sda_pkg::ST_NB;
            end
         end
         sda_pkg::ST_SELF: begin
            if (self_ff >= sda_pkg::TOPPLE_AT && q_room) begin
               q_we     = 1'b1;
               q_wdata  = cur_ff;
               tail_in  = tail_ff + ADDR_W'(1);
               count_in = count_ff + (ADDR_W + 1)'(1);
            end
            state_in = sda_pkg::ST_POP;
         end
         sda_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = size_ff;
               state_in     = sda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sda_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sda_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      cur_ff      <= cur_in;
      self_ff     <= self_in;
      nb_ff       <= nb_in;
      size_ff     <= size_in;
      rsp_data_ff <= rsp_data_in;
   end

   // grid memory
   always_ff @(posedge clock) begin
      if (g_we) begin
         grain_mem_ff[g_waddr] <= g_wdata;
      end
      if (g_re) begin
         grain_rd_ff <= grain_mem_ff[g_raddr];
      end
   end

   // work list memory
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem_ff[q_waddr] <= q_wdata;
      end
      if (q_re) begin
         queue_rd_ff <= queue_mem_ff[head_ff];
      end
   end

   `SDA_ASSERT(a_queue_bound, count_ff <= Q_FULL, "work list over capacity")
   `SDA_ASSERT(a_queue_ptrs, count_ff[ADDR_W-1:0] == ADDR_W'(tail_ff - head_ff), "work list pointers disagree with count")
   `SDA_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff == sda_pkg::ST_DROP_WR || state_ff == sda_pkg::ST_DONE, "accepted drop did not start")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives single-grain drops into the sandpile unit and checks each avalanche
// size against a grid model that topples cells from a fifo work list, with a
// directed opening on corners, interior cells and a chained interior avalanche,
// then random drops clustered into small windows so the grid goes critical
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE           = sda_pkg::GRID_SIDE_DEF;
   localparam int RANDOM_DROPS   = 500;
   localparam int BURST_LEN      = 50;
   localparam int STALL_LIMIT    = 300000;
   localparam int DRAIN_CYCLES   = 64;

   class avalanche_board;
      logic [sda_pkg::GRAIN_W-1:0] grains [SIDE*SIDE];
      int unsigned                 work_list [$];
      logic [sda_pkg::SIZE_W-1:0]  expected_sizes [$];
      int unsigned                 failures;

      function new();
         foreach (grains[i]) grains[i] = '0;
         failures = 0;
      endfunction

      function void bump(input int unsigned site);
         if (grains[site] != sda_pkg::GRAIN_MAX) grains[site] = grains[site] + 1'b1;
      endfunction

      function void feed(input int unsigned col, input int unsigned row);
         int unsigned site;
         site = row * SIDE + col;
         bump(site);
         if (grains[site] == sda_pkg::TOPPLE_AT) work_list.push_back(site);
      endfunction

      function void note_drop(input logic [sda_pkg::COORD_IN_W-1:0] col_in,
                              input logic [sda_pkg::COORD_IN_W-1:0] row_in);
         int unsigned                start;
         int unsigned                site;
         int unsigned                col;
         int unsigned                row;
         logic [sda_pkg::SIZE_W-1:0] topplings;
         topplings = '0;
         if (col_in < SIDE && row_in < SIDE) begin
            start = row_in * SIDE + col_in;
            bump(start);
            if (grains[start] >= sda_pkg::TOPPLE_AT) begin
               work_list.delete();
               work_list.push_back(start);
               while (work_list.size() != 0) begin
                  site = work_list.pop_front();
                  if (grains[site] >= sda_pkg::TOPPLE_AT) begin
                     grains[site] = grains[site] - sda_pkg::TOPPLE_AT;
                     if (topplings != sda_pkg::SIZE_MAX) topplings = topplings + 1'b1;
                     col = site % SIDE;
                     row = site / SIDE;
                     if (row + 1 < SIDE) feed(col, row + 1);
                     if (row > 0) feed(col, row - 1);
                     if (col + 1 < SIDE) feed(col + 1, row);
                     if (col > 0) feed(col - 1, row);
                     if (grains[site] >= sda_pkg::TOPPLE_AT) work_list.push_back(site);
                  end
               end
            end
         end
         expected_sizes.push_back(topplings);
      endfunction

      function void check_size(input logic [sda_pkg::SIZE_W-1:0] actual);
         logic [sda_pkg::SIZE_W-1:0] want;
         if (expected_sizes.size() == 0) begin
            $error("topple_count: got %0d with no drop outstanding", actual);
            failures++;
         end else begin
            want = expected_sizes.pop_front();
            if (actual !== want) begin
               $error("topple_count: expected %0d, actual %0d", want, actual);
               failures++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_sizes.size();
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [sda_pkg::REQ_DATA_W-1:0] req_tdata;   // drop_x, drop_y, zero fill
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [sda_pkg::SIZE_W-1:0]     rsp_tdata;   // topple count

   avalanche_board board = new();
   int             sender_idle_pct;
   int             receiver_idle_pct;
   int             quiet_cycles;

   sandpile_drop_avalanche_unit #(
      .GRID_SIDE(SIDE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_size(rsp_tdata);
   end

   // no word moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drop_grain(input logic [sda_pkg::COORD_IN_W-1:0] col,
                             input logic [sda_pkg::COORD_IN_W-1:0] row);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sda_pkg::REQ_DATA_W'({row, col});
      do @(posedge clock); while (!req_tready);
      board.note_drop(col, row);
   endtask

   function automatic int pick_origin(input int span);
      case ($urandom_range(2))
         0: return 0;
         1: return SIDE - span;
         default: return $urandom_range(SIDE - span);
      endcase
   endfunction

   initial begin
      int win_x;
      int win_y;
      int win_w;
      logic [sda_pkg::COORD_IN_W-1:0] col;
      logic [sda_pkg::COORD_IN_W-1:0] row;

      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      sender_idle_pct   = 38;
      receiver_idle_pct = 57;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // corners and interior cells, a corner topple loses two grains off the grid
      repeat (4) drop_grain(6'd0, 6'd0);
      repeat (4) drop_grain(6'd63, 6'd63);
      drop_grain(6'd63, 6'd0);
      drop_grain(6'd0, 6'd63);
      drop_grain(6'd42, 6'd21);
      drop_grain(6'd21, 6'd42);
      // interior topple, then a chain through two loaded neighbours
      repeat (4) drop_grain(6'd32, 6'd32);
      repeat (3) drop_grain(6'd32, 6'd32);
      repeat (2) drop_grain(6'd31, 6'd32);
      repeat (2) drop_grain(6'd33, 6'd32);
      drop_grain(6'd32, 6'd32);

      win_x = 0;
      win_y = 0;
      win_w = 1;
      for (int n = 0; n < RANDOM_DROPS; n++) begin
         if (n == RANDOM_DROPS / 3) begin
            sender_idle_pct   = 57;
            receiver_idle_pct = 38;
         end else if (n == 2 * RANDOM_DROPS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (n % BURST_LEN == 0 && (n == 0 || $urandom_range(1) == 1)) begin
            win_w = $urandom_range(6, 1);
            win_x = pick_origin(win_w);
            win_y = pick_origin(win_w);
         end
         if ($urandom_range(99) < 80) begin
            col = sda_pkg::COORD_IN_W'(win_x + $urandom_range(win_w - 1));
            row = sda_pkg::COORD_IN_W'(win_y + $urandom_range(win_w - 1));
         end else begin
            col = sda_pkg::COORD_IN_W'($urandom_range(SIDE - 1));
            row = sda_pkg::COORD_IN_W'($urandom_range(SIDE - 1));
         end
         drop_grain(col, row);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sandpile_drop_avalanche_unit.f =====
+incdir+rtl/core
rtl/core/sda_pkg.sv
rtl/core/sandpile_drop_avalanche_unit.sv
sim/tb_top.sv
